// ===== design/b2d_pkg.sv =====
// Shared types, constants and helpers for the binary to decimal ASCII converter.
`default_nettype none

package b2d_pkg;

   localparam int VALUE_W = 20;
   localparam int VALUE_DIGITS = 7;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W = 6;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   localparam logic [VALUE_W+3:0] RECIP10 = 24'd838861;
   localparam int RECIP_SHIFT = 23;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NUL = 6'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stk_ctrl_type;

   typedef struct packed {
      logic empty;
      logic last_slot;
   } stk_stat_type;

   function automatic logic [63:0] pow10(input int n);
      logic [63:0] acc;
      acc = 64'd1;
      for (int k = 0; k < n; k++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

// ===== design/b2d_div10.sv =====
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder by subtracting a shift-add ten times quotient.
`default_nettype none

module b2d_div10 (
   input  wire logic [b2d_pkg::VALUE_W-1:0] dividend,
   output logic [b2d_pkg::VALUE_W-1:0]      quotient,
   output logic [b2d_pkg::DIGIT_W-1:0]      remainder
);
   import b2d_pkg::*;

   logic [2*VALUE_W+3:0] prod;
   logic [VALUE_W+3:0]   q_times10;
   logic [VALUE_W+3:0]   diff;

   always_comb begin
      prod = {4'd0, dividend} * {{VALUE_W{1'b0}}, RECIP10};
      quotient = prod[RECIP_SHIFT+VALUE_W-1:RECIP_SHIFT];
      q_times10 = {1'b0, quotient, 3'd0} + {3'd0, quotient, 1'b0};
      diff = {4'd0, dividend} - q_times10;
      remainder = diff[DIGIT_W-1:0];
   end

endmodule

`default_nettype wire

// ===== design/b2d_stack.sv =====
// Digit stack: remainders pushed least significant first, popped most significant first.
`default_nettype none

module b2d_stack #(
   parameter int DEPTH = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire b2d_pkg::stk_ctrl_type      ctrl,
   input  wire logic [b2d_pkg::DIGIT_W-1:0] push_digit,
   output b2d_pkg::stk_stat_type           stat,
   output logic [b2d_pkg::DIGIT_W-1:0]     top_digit
);
   import b2d_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DIGIT_W-1:0] dig_ff [DEPTH];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [CNT_W-1:0]   cnt_dec;
   logic [IDX_W-1:0]   top_idx;

   always_comb begin
      cnt_dec = cnt_ff - CNT_W'(1);
      top_idx = cnt_dec[IDX_W-1:0];
      top_digit = dig_ff[top_idx];
      stat.empty = (cnt_ff == '0);
      stat.last_slot = (cnt_ff == CNT_W'(DEPTH - 1));
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         cnt_in = '0;
      end else if (ctrl.push) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctrl.pop) begin
         cnt_in = cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (ctrl.push && !ctrl.clear && (cnt_ff == CNT_W'(i))) begin
            dig_ff[i] <= push_digit;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_push_pop: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop))
      else $error("stack push and pop in the same cycle");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (ctrl.pop && !ctrl.clear) |-> (cnt_ff != '0))
      else $error("stack pop while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.clear) |-> (cnt_ff < CNT_W'(DEPTH)))
      else $error("stack push while full");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("stack count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== design/binary_to_decimal_ascii_top.sv =====
// Top level: sequencer around the divide-by-ten unit and digit stack, with output register.
// An accepted value with d decimal digits is divided in ST_DIV; ST_EMIT then sends its
// d digits most significant first and a NUL terminator with rsp_tlast, pausing on stalls.
// Requests are taken only in ST_IDLE; out-of-range values are dropped with no response.
// The single divide-by-ten unit, one digit per cycle, sets the rate.
// Synchronous active-high reset clears the sequencer, digit count and output valid.
`default_nettype none

module binary_to_decimal_ascii_top #(
   parameter int MAX_DIGITS = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [b2d_pkg::REQ_DATA_W-1:0] req_tdata,  // [19:0] value
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [b2d_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [5:0] character
   output logic                               rsp_tlast
);
   import b2d_pkg::*;

   localparam int DEPTH = (MAX_DIGITS < VALUE_DIGITS) ? MAX_DIGITS : VALUE_DIGITS;
   localparam logic [63:0] LIMIT = pow10(MAX_DIGITS);

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VALUE_W-1:0]   quotient;
   logic [DIGIT_W-1:0]   remainder;
   logic [DIGIT_W-1:0]   top_digit;
   stk_ctrl_type         stk_ctrl;
   stk_stat_type         stk_stat;
   logic                 out_free;
   logic                 in_range;

   b2d_div10 u_div10 (
      .dividend  (val_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   b2d_stack #(
      .DEPTH (DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (stk_ctrl),
      .push_digit (remainder),
      .stat       (stk_stat),
      .top_digit  (top_digit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      stk_ctrl = '0;
      out_free = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      in_range = ({44'd0, req_tdata[VALUE_W-1:0]} < LIMIT);
      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_in = req_tdata[VALUE_W-1:0];
               stk_ctrl.clear = 1'b1;
               if (in_range) begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            stk_ctrl.push = 1'b1;
            val_in = quotient;
            if ((quotient == '0) || stk_stat.last_slot) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!stk_stat.empty) begin
                  stk_ctrl.pop = 1'b1;
                  rsp_char_in = ASCII_ZERO + {2'd0, top_digit};
                  rsp_last_in = 1'b0;
               end else begin
                  rsp_char_in = ASCII_NUL;
                  rsp_last_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - CHAR_W){1'b0}}, rsp_char_ff};
   assign rsp_tlast = rsp_last_ff;

`ifndef ASSERT_OFF
   a_last_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && stk_stat.empty) |=> (rsp_tvalid && rsp_tlast))
      else $error("terminator not issued after last digit");
   a_digit_is_ascii: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata >= 8'd48 && rsp_tdata <= 8'd57))
      else $error("digit result outside ASCII digit range");
   a_terminator_is_nul: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == '0))
      else $error("terminator carries nonzero data");
`endif

endmodule

`default_nettype wire
